[rtl/core/pdef_pkg.sv]
// Shared types, constants and codes for the pen report deadband/EMA filter.
`default_nettype none
package pdef_pkg;

  localparam int RawReportBytes       = 8;
  localparam int PrependedReportBytes = 9;

  localparam logic [7:0] PEN_ID     = 8'h02;
  localparam logic [7:0] ST_TIP     = 8'h01;
  localparam logic [7:0] ST_BARREL1 = 8'h02;
  localparam logic [7:0] ST_BARREL2 = 8'h04;
  localparam logic [7:0] ST_ERASER  = 8'h08;
  localparam logic [7:0] ST_PROX    = 8'h40;
  localparam logic [6:0] STRENGTH_CAP = 7'd95;
  localparam logic [6:0] PERCENT      = 7'd100;

  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    KIND_IGNORED = 2'd0,
    KIND_OUT_PROX = 2'd1,
    KIND_SAMPLE  = 2'd2
  } kind_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_DEADZONE    = 3'd0;
  localparam logic [2:0] REG_DZ_SQUARED  = 3'd1;
  localparam logic [2:0] REG_SMOOTH_EN   = 3'd2;
  localparam logic [2:0] REG_SMOOTH_STR  = 3'd3;
  localparam logic [2:0] REG_TIP_THRESH  = 3'd4;
  localparam logic [2:0] REG_TIP_DISABLE = 3'd5;
  localparam logic [2:0] REG_PRESSURE_EN = 3'd6;

  typedef struct packed {
    logic [6:0] pkt_length;
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic [7:0] byte_4;
    logic [7:0] byte_5;
    logic [7:0] byte_6;
    logic [7:0] byte_7;
    logic [7:0] byte_8;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
    logic [15:0] pressure;
    logic [3:0]  buttons;
  } out_item_t;

  // Decoded report handed from the front end to the filter.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
    logic [15:0] pressure;
    logic [3:0]  buttons;
  } dec_item_t;

  typedef struct packed {
    logic [9:0]  deadzone;
    logic [19:0] deadzone_squared;
    logic        smoothing_enable;
    logic [6:0]  smoothing_strength;
    logic [15:0] tip_threshold;
    logic        tip_click_disable;
    logic        pressure_enable;
  } cfg_t;

endpackage
`default_nettype wire

[rtl/core/pen_report_deadzone_ema_filter_top.sv]
// Top level of the pen report deadband and moving-average filter.
// Usage: push one report (length and nine bytes) on in_ while in_full is low;
// each report yields exactly one result on out_, popped while out_empty is low.
// Results keep report order. Configuration is written through cfg_valid and
// cfg_ready (always ready); the user must do so only while the block is idle,
// which the block itself does not enforce. A transfer enters a two-entry queue
// after decode in the same cycle. Ignored, out-of-proximity and first-sample
// reports go straight to the result; other samples run the average, and when
// the deadband moves they first run 17 square-root steps and two 34-step
// divides for the anchor shift. With smoothing on, the average takes two
// reciprocal divides by 100, on the shared bit-serial root and divide unit.
// The filter takes a new report only when it is idle and its last result has
// been popped.
// Reset clears the filter to unprimed, the anchor and average to zero and the
// registers to their reset values (pressure reporting on).
// When the receiver stalls, the finished result holds on out_; the queue
// still accepts up to two further reports before in_full rises.
`default_nettype none
module pen_report_deadzone_ema_filter_top #(
  parameter int QueueDepth = pdef_pkg::QueueDepth
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_push,
  input  wire pdef_pkg::in_item_t   in_data,
  output logic                      in_full,
  output logic                      out_empty,
  input  wire                       out_pop,
  output pdef_pkg::out_item_t       out_data,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire [2:0]                 cfg_index,
  input  wire [19:0]                cfg_wdata
);
  import pdef_pkg::*;

  localparam cfg_t CfgReset = '{deadzone: '0, deadzone_squared: '0, smoothing_enable: 1'b0,
                                smoothing_strength: '0, tip_threshold: '0,
                                tip_click_disable: 1'b0, pressure_enable: 1'b1};

  cfg_t      cfg_r;
  dec_item_t dec, q_data;
  logic      q_empty, q_pop, out_valid;

  assign cfg_ready = 1'b1;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CfgReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEADZONE:    cfg_r.deadzone           <= cfg_wdata[9:0];
        REG_DZ_SQUARED:  cfg_r.deadzone_squared   <= cfg_wdata;
        REG_SMOOTH_EN:   cfg_r.smoothing_enable   <= cfg_wdata[0];
        REG_SMOOTH_STR:  cfg_r.smoothing_strength <= cfg_wdata[6:0];
        REG_TIP_THRESH:  cfg_r.tip_threshold      <= cfg_wdata[15:0];
        REG_TIP_DISABLE: cfg_r.tip_click_disable  <= cfg_wdata[0];
        REG_PRESSURE_EN: cfg_r.pressure_enable    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  pdef_front u_front (.item(in_data), .cfg(cfg_r), .dec(dec));

  pdef_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(in_push), .wdata(dec), .full(in_full),
    .pop(q_pop), .empty(q_empty), .rdata(q_data)
  );

  pdef_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_empty(q_empty), .q_data(q_data),
    .q_pop(q_pop), .out_valid(out_valid), .out_data(out_data), .out_pop(out_pop)
  );

  assign out_empty = !out_valid;

  // A result stays put until it is popped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("result changed while stalled");

  // Only sample results carry coordinates.
  a_non_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.kind != KIND_SAMPLE) |-> (out_data.pos_x == 16'd0))
    else $error("non-sample result carries position");

  // The back end takes from the queue only when it holds something.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule
`default_nettype wire

[rtl/core/pdef_front.sv]
// Front end: report alignment, ID check, field decode and button flags.
`default_nettype none
module pdef_front (
  input  wire pdef_pkg::in_item_t  item,
  input  wire pdef_pkg::cfg_t      cfg,
  output pdef_pkg::dec_item_t      dec
);
  import pdef_pkg::*;

  logic [7:0] b [9];
  logic       off;
  logic [7:0] id, status;
  logic [15:0] rx, ry, rp;
  logic        tip;

  always_comb begin
    b[0] = item.byte_0; b[1] = item.byte_1; b[2] = item.byte_2;
    b[3] = item.byte_3; b[4] = item.byte_4; b[5] = item.byte_5;
    b[6] = item.byte_6; b[7] = item.byte_7; b[8] = item.byte_8;
    // A prepended byte shifts the report one place.
    off = (item.pkt_length >= 7'(PrependedReportBytes)) && (b[0] != PEN_ID) &&
          (b[1] == PEN_ID);
    id     = off ? b[1] : b[0];
    status = off ? b[2] : b[1];
    rx = off ? {b[4], b[3]} : {b[3], b[2]};
    ry = off ? {b[6], b[5]} : {b[5], b[4]};
    rp = off ? {b[8], b[7]} : {b[7], b[6]};
    tip = !cfg.tip_click_disable && (((status & ST_TIP) != 8'd0) ||
          ((cfg.tip_threshold != 16'd0) && (rp >= cfg.tip_threshold)));
    dec = '0;
    dec.kind = KIND_IGNORED;
    if ((item.pkt_length >= 7'(RawReportBytes)) && (id == PEN_ID)) begin
      if ((status & ST_PROX) == 8'd0) begin
        dec.kind = KIND_OUT_PROX;
      end else begin
        dec.kind     = KIND_SAMPLE;
        dec.raw_x    = rx;
        dec.raw_y    = ry;
        dec.pressure = cfg.pressure_enable ? rp : 16'd0;
        dec.buttons  = {(status & ST_ERASER) != 8'd0, (status & ST_BARREL2) != 8'd0,
                        (status & ST_BARREL1) != 8'd0, tip};
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/pdef_queue.sv]
// Small register queue between the front end and the filter.
`default_nettype none
module pdef_queue #(
  parameter int Depth = pdef_pkg::QueueDepth
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       push,
  input  wire pdef_pkg::dec_item_t  wdata,
  output logic                      full,
  input  wire                       pop,
  output logic                      empty,
  output pdef_pkg::dec_item_t       rdata
);
  import pdef_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  dec_item_t             mem_r [Depth];
  logic [AW-1:0]         wp_r, rp_r;
  logic [$clog2(Depth+1)-1:0] cnt_r;

  assign full  = (cnt_r == ($bits(cnt_r))'(Depth));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  // Storage is written on each accepted transfer.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop && !empty) begin
        rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + ($bits(cnt_r))'(push && !full) - ($bits(cnt_r))'(pop && !empty);
    end
  end

endmodule
`default_nettype wire

[rtl/core/pdef_back.sv]
// Back end: deadband with iterative square root and divide, then EMA.
`default_nettype none
module pdef_back (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire pdef_pkg::cfg_t       cfg,
  input  wire                       q_empty,
  input  wire pdef_pkg::dec_item_t  q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  output pdef_pkg::out_item_t       out_data,
  input  wire                       out_pop
);
  import pdef_pkg::*;

  // Rounded-up 2^34 / 100; exact floor division for dividends below 2^27.
  localparam logic [27:0] DIV100_MUL = 28'd171798692;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SQRT  = 9'b000000010,
    S_MULX  = 9'b000000100,
    S_DIVX  = 9'b000001000,
    S_DIVY  = 9'b000010000,
    S_EMAX  = 9'b000100000,
    S_EMAY  = 9'b001000000,
    S_EDIV  = 9'b010000000,
    S_DONE  = 9'b100000000
  } st_t;

  st_t         st_r;
  dec_item_t   it_r;
  logic        primed_r;
  logic [15:0] ax_r, ay_r;
  logic [31:0] sx_r, sy_r;
  logic [15:0] px_r, py_r;
  logic        out_valid_r;
  out_item_t   out_r;

  // Shared work registers for sqrt and division.
  logic [16:0] dxm_r, dym_r;      // magnitudes
  logic        dxs_r, dys_r;      // signs
  logic [33:0] rem_r;             // sqrt / divide remainder
  logic [33:0] root_r;
  logic [4:0]  cnt_r;
  logic [16:0] dist_r;
  logic [16:0] excess_r;
  logic [33:0] num_r;
  logic [33:0] quo_r;
  logic [5:0]  dcnt_r;
  logic        ysel_r;
  // EMA registers.
  logic [6:0]  str_r;
  logic [38:0] eacc_r;
  logic [38:0] eq_r;
  logic        eph_r;

  logic [16:0] dxm, dym;
  logic        dxs, dys;
  logic [33:0] dsq;
  logic [34:0] drem;

  always_comb begin
    dxs = q_data.raw_x < ax_r;
    dys = q_data.raw_y < ay_r;
    dxm = dxs ? 17'(ax_r) - 17'(q_data.raw_x) : 17'(q_data.raw_x) - 17'(ax_r);
    dym = dys ? 17'(ay_r) - 17'(q_data.raw_y) : 17'(q_data.raw_y) - 17'(ay_r);
    dsq = 34'(dxm) * 34'(dxm) + 34'(dym) * 34'(dym);
  end

  assign q_pop     = (st_r == S_IDLE) && !q_empty && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic [33:0] rt_bit;
  logic [33:0] rt_cmp;
  always_comb begin
    // Restoring sqrt: one result bit per step, from two radicand bits.
    rt_bit = 34'd1 << {cnt_r, 1'b0};
    rt_cmp = root_r + rt_bit;
    drem   = {rem_r, 1'b0} | 35'(num_r[33]);
  end

  // Division by 100 in two passes: the high part of the sum, then the
  // remainder joined with the low 20 bits.
  logic [26:0] dv_x;
  logic [54:0] dv_prod;
  logic [20:0] dv_q;
  logic [6:0]  dv_r;
  logic [31:0] ediv_q;
  always_comb begin
    dv_x    = eph_r ? {rem_r[6:0], eacc_r[19:0]} : {8'd0, eacc_r[38:20]};
    dv_prod = 55'(dv_x) * 55'(DIV100_MUL);
    dv_q    = dv_prod[54:34];
    dv_r    = 7'(dv_x - 27'(dv_q) * 27'(PERCENT));
    ediv_q  = eq_r[31:0] | 32'(dv_q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      primed_r    <= 1'b0;
      ax_r        <= '0;
      ay_r        <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_pop) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (q_pop) begin
            it_r  <= q_data;
            dxm_r <= dxm; dym_r <= dym; dxs_r <= dxs; dys_r <= dys;
            str_r <= (cfg.smoothing_strength > STRENGTH_CAP) ? STRENGTH_CAP
                                                             : cfg.smoothing_strength;
            if (q_data.kind != KIND_SAMPLE) begin
              if (q_data.kind == KIND_OUT_PROX) primed_r <= 1'b0;
              st_r <= S_DONE;
            end else if (!primed_r) begin
              sx_r <= {q_data.raw_x, 16'd0};
              sy_r <= {q_data.raw_y, 16'd0};
              ax_r <= q_data.raw_x;
              ay_r <= q_data.raw_y;
              px_r <= q_data.raw_x;
              py_r <= q_data.raw_y;
              primed_r <= 1'b1;
              st_r <= S_DONE;
            end else if (cfg.deadzone == 10'd0) begin
              ax_r <= q_data.raw_x;
              ay_r <= q_data.raw_y;
              px_r <= q_data.raw_x;
              py_r <= q_data.raw_y;
              st_r <= S_EMAX;
            end else if (dsq > 34'(cfg.deadzone_squared)) begin
              rem_r  <= dsq;
              root_r <= '0;
              cnt_r  <= 5'd16;
              st_r   <= S_SQRT;
            end else begin
              px_r <= ax_r;
              py_r <= ay_r;
              st_r <= S_EMAX;
            end
          end
        end
        S_SQRT: begin
          // One result bit per cycle, as in the bit-pair method.
          if (rem_r >= rt_cmp) begin
            rem_r  <= rem_r - rt_cmp;
            root_r <= (root_r >> 1) + rt_bit;
          end else begin
            root_r <= root_r >> 1;
          end
          if (cnt_r == 5'd0) begin
            st_r <= S_MULX;
          end
          cnt_r <= cnt_r - 5'd1;
        end
        S_MULX: begin
          // Clamp distance, form excess and clear the numerator.
          dist_r   <= (root_r == 34'd0) ? 17'd1 : root_r[16:0];
          excess_r <= (root_r[16:0] > 17'(cfg.deadzone)) ? root_r[16:0] - 17'(cfg.deadzone)
                                                         : 17'd0;
          ysel_r   <= 1'b0;
          num_r    <= '0;
          st_r     <= S_DIVX;
          dcnt_r   <= 6'd0;
        end
        S_DIVX: begin
          // Load numerator |d| * excess for the current axis.
          num_r  <= 34'(ysel_r ? dym_r : dxm_r) * 34'(excess_r);
          rem_r  <= '0;
          quo_r  <= '0;
          dcnt_r <= 6'd34;
          st_r   <= S_DIVY;
        end
        S_DIVY: begin
          // Restoring divide, one quotient bit per cycle.
          if (dcnt_r != 6'd0) begin
            if (drem >= 35'(dist_r)) begin
              rem_r <= 34'(drem - 35'(dist_r));
              quo_r <= {quo_r[32:0], 1'b1};
            end else begin
              rem_r <= drem[33:0];
              quo_r <= {quo_r[32:0], 1'b0};
            end
            num_r  <= {num_r[32:0], 1'b0};
            dcnt_r <= dcnt_r - 6'd1;
          end else if (!ysel_r) begin
            ax_r   <= dxs_r ? ax_r - quo_r[15:0] : ax_r + quo_r[15:0];
            px_r   <= dxs_r ? ax_r - quo_r[15:0] : ax_r + quo_r[15:0];
            ysel_r <= 1'b1;
            st_r   <= S_DIVX;
          end else begin
            ay_r <= dys_r ? ay_r - quo_r[15:0] : ay_r + quo_r[15:0];
            py_r <= dys_r ? ay_r - quo_r[15:0] : ay_r + quo_r[15:0];
            st_r <= S_EMAX;
          end
        end
        S_EMAX: begin
          if (cfg.smoothing_enable && (cfg.smoothing_strength != 7'd0)) begin
            eacc_r <= 39'(sx_r) * 39'(str_r) + 39'({px_r, 16'd0}) * 39'(PERCENT - str_r);
            ysel_r <= 1'b0;
            st_r   <= S_EDIV;
            eph_r  <= 1'b0;
            eq_r   <= '0;
            rem_r  <= '0;
          end else begin
            sx_r <= {px_r, 16'd0};
            sy_r <= {py_r, 16'd0};
            st_r <= S_DONE;
          end
        end
        S_EMAY: begin
          eacc_r <= 39'(sy_r) * 39'(str_r) + 39'({py_r, 16'd0}) * 39'(PERCENT - str_r);
          ysel_r <= 1'b1;
          st_r   <= S_EDIV;
          eph_r  <= 1'b0;
          eq_r   <= '0;
          rem_r  <= '0;
        end
        S_EDIV: begin
          // Divide by 100 by reciprocal multiplication: high part, then remainder with low bits.
          if (!eph_r) begin
            eq_r  <= {dv_q[18:0], 20'd0};
            rem_r <= 34'(dv_r);
            eph_r <= 1'b1;
          end else if (!ysel_r) begin
            sx_r <= ediv_q;
            px_r <= ediv_q[31:16];
            st_r <= S_EMAY;
          end else begin
            sy_r <= ediv_q;
            py_r <= ediv_q[31:16];
            st_r <= S_DONE;
          end
        end
        S_DONE: begin
          out_r.kind     <= it_r.kind;
          out_r.pos_x    <= (it_r.kind == KIND_SAMPLE) ? px_r : 16'd0;
          out_r.pos_y    <= (it_r.kind == KIND_SAMPLE) ? py_r : 16'd0;
          out_r.raw_x    <= it_r.raw_x;
          out_r.raw_y    <= it_r.raw_y;
          out_r.pressure <= it_r.pressure;
          out_r.buttons  <= it_r.buttons;
          out_valid_r    <= 1'b1;
          st_r           <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[verif/pen_report_deadzone_ema_filter_top_tb.sv]
// Self-checking testbench for the pen report deadband and moving-average filter.
`timescale 1ns / 1ps
`default_nettype none
module pen_report_deadzone_ema_filter_top_tb;
  import pdef_pkg::*;

  localparam int LimitCycles = 900000;
  localparam int DrainCycles = 300;

  logic clk;
  logic rst_n;
  logic in_push;
  in_item_t in_data;
  logic in_full;
  logic out_empty;
  logic out_pop;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [19:0] cfg_wdata;

  pen_report_deadzone_ema_filter_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Predictor copy of the register file and filter state.
  cfg_t        shadow_cfg;
  logic        pred_primed;
  logic [15:0] pred_anchor_x;
  logic [15:0] pred_anchor_y;
  logic [31:0] pred_smooth_x;
  logic [31:0] pred_smooth_y;

  in_item_t  report_queue[$];
  out_item_t expected_results[$];
  int        sender_idle_pct;
  int        receiver_stall_pct;
  int        mismatch_count;
  int        cycle_count;

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] ema_blend(input logic [63:0] prev, input logic [15:0] target,
                                            input logic [6:0] strength);
    logic [63:0] t16;
    t16 = {32'd0, target, 16'd0};
    return (prev * strength + t16 * (64'd100 - strength)) / 64'd100;
  endfunction

  // Works out the result of one report and advances the filter state.
  function automatic out_item_t filter_report(input in_item_t it);
    out_item_t   res;
    logic [7:0]  b[9];
    int          off;
    logic [7:0]  status;
    logic [15:0] rx, ry, rp, px, py;
    longint      dx, dy, root_dist, excess;
    logic [63:0] dsq;
    logic [6:0]  s;
    logic        tip;
    res = '0;
    b[0] = it.byte_0; b[1] = it.byte_1; b[2] = it.byte_2; b[3] = it.byte_3;
    b[4] = it.byte_4; b[5] = it.byte_5; b[6] = it.byte_6; b[7] = it.byte_7;
    b[8] = it.byte_8;
    off = 0;
    res.kind = KIND_IGNORED;
    if (it.pkt_length < RawReportBytes) return res;
    if (it.pkt_length >= PrependedReportBytes && b[0] != PEN_ID && b[1] == PEN_ID) off = 1;
    if (b[off] != PEN_ID) return res;
    status = b[off + 1];
    if ((status & ST_PROX) == 0) begin
      pred_primed = 1'b0;
      res.kind = KIND_OUT_PROX;
      return res;
    end
    rx = {b[off + 3], b[off + 2]};
    ry = {b[off + 5], b[off + 4]};
    rp = {b[off + 7], b[off + 6]};
    px = rx;
    py = ry;
    if (!pred_primed) begin
      pred_smooth_x = {rx, 16'd0};
      pred_smooth_y = {ry, 16'd0};
      pred_anchor_x = rx;
      pred_anchor_y = ry;
      pred_primed = 1'b1;
    end else begin
      if (shadow_cfg.deadzone > 0) begin
        dx = longint'(rx) - longint'(pred_anchor_x);
        dy = longint'(ry) - longint'(pred_anchor_y);
        dsq = dx * dx + dy * dy;
        if (dsq > shadow_cfg.deadzone_squared) begin
          root_dist = longint'(root_floor(dsq));
          if (root_dist == 0) root_dist = 1;
          excess = root_dist - longint'(shadow_cfg.deadzone);
          if (excess < 0) excess = 0;
          pred_anchor_x = 16'(longint'(pred_anchor_x) + (dx * excess) / root_dist);
          pred_anchor_y = 16'(longint'(pred_anchor_y) + (dy * excess) / root_dist);
        end
        px = pred_anchor_x;
        py = pred_anchor_y;
      end else begin
        pred_anchor_x = rx;
        pred_anchor_y = ry;
      end
      if (shadow_cfg.smoothing_enable && shadow_cfg.smoothing_strength > 0) begin
        s = shadow_cfg.smoothing_strength;
        if (s > STRENGTH_CAP) s = STRENGTH_CAP;
        pred_smooth_x = 32'(ema_blend({32'd0, pred_smooth_x}, px, s));
        pred_smooth_y = 32'(ema_blend({32'd0, pred_smooth_y}, py, s));
        px = pred_smooth_x[31:16];
        py = pred_smooth_y[31:16];
      end else begin
        pred_smooth_x = {px, 16'd0};
        pred_smooth_y = {py, 16'd0};
      end
    end
    tip = !shadow_cfg.tip_click_disable &&
          ((status & ST_TIP) != 0 ||
           (shadow_cfg.tip_threshold > 0 && rp >= shadow_cfg.tip_threshold));
    res.kind = KIND_SAMPLE;
    res.pos_x = px;
    res.pos_y = py;
    res.raw_x = rx;
    res.raw_y = ry;
    res.pressure = shadow_cfg.pressure_enable ? rp : 16'd0;
    res.buttons = {status[3], status[2], status[1], tip};
    return res;
  endfunction

  // Builds a report; shape picks a pen report, a prepended one, a short one or noise.
  function automatic in_item_t make_report(input int shape);
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom}));
    it.pkt_length = 7'($urandom_range(8, 64));
    case (shape)
      0: begin
        it.byte_0 = PEN_ID;
        it.byte_1 = ($urandom_range(0, 9) == 0) ? it.byte_1 & ~ST_PROX : it.byte_1 | ST_PROX;
      end
      1: begin
        it.pkt_length = 7'($urandom_range(9, 127));
        it.byte_1 = PEN_ID;
        if (it.byte_0 == PEN_ID) it.byte_0 = 8'h03;
        it.byte_2 = it.byte_2 | ST_PROX;
      end
      2: it.pkt_length = 7'($urandom_range(0, 7));
      default: it.pkt_length = 7'($urandom_range(0, 127));
    endcase
    // Small moves around a drifting point keep the deadband in play.
    if (shape == 0 && $urandom_range(0, 2) != 0) begin
      it.byte_3 = 8'h40 + 8'($urandom_range(0, 3));
      it.byte_5 = 8'h20 + 8'($urandom_range(0, 3));
    end
    return it;
  endfunction

  function automatic in_item_t pen_report(input logic [7:0] status, input logic [15:0] x,
                                          input logic [15:0] y, input logic [15:0] p);
    in_item_t it;
    it = '0;
    it.pkt_length = 7'd8;
    it.byte_0 = PEN_ID;
    it.byte_1 = status;
    {it.byte_3, it.byte_2} = x;
    {it.byte_5, it.byte_4} = y;
    {it.byte_7, it.byte_6} = p;
    return it;
  endfunction

  // Driver: pushes pending reports, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (in_push && !in_full) begin
      if (report_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        in_data <= report_queue.pop_front();
        in_push <= 1'b1;
      end else begin
        in_push <= 1'b0;
      end
    end else if (!in_push) begin
      if (report_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        in_data <= report_queue.pop_front();
        in_push <= 1'b1;
      end
    end
  end

  // Prediction at each accepted transfer on the input side.
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) expected_results.push_back(filter_report(in_data));
  end

  // Monitor: pops results and compares them with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("Unexpected result %p", out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) $display("Mismatch: expected %p, got %p", want, out_data);
          end
        end
      end
      out_pop <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic wait_idle();
    while (report_queue.size() > 0 || in_push || expected_results.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DEADZONE:    shadow_cfg.deadzone = val[9:0];
      REG_DZ_SQUARED:  shadow_cfg.deadzone_squared = val;
      REG_SMOOTH_EN:   shadow_cfg.smoothing_enable = val[0];
      REG_SMOOTH_STR:  shadow_cfg.smoothing_strength = val[6:0];
      REG_TIP_THRESH:  shadow_cfg.tip_threshold = val[15:0];
      REG_TIP_DISABLE: shadow_cfg.tip_click_disable = val[0];
      REG_PRESSURE_EN: shadow_cfg.pressure_enable = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_all(input int dz, input int dzsq, input int sen, input int str,
                         input int thr, input int tdis, input int pen);
    write_reg(REG_DEADZONE, 20'(dz));
    write_reg(REG_DZ_SQUARED, 20'(dzsq));
    write_reg(REG_SMOOTH_EN, 20'(sen));
    write_reg(REG_SMOOTH_STR, 20'(str));
    write_reg(REG_TIP_THRESH, 20'(thr));
    write_reg(REG_TIP_DISABLE, 20'(tdis));
    write_reg(REG_PRESSURE_EN, 20'(pen));
  endtask

  task automatic random_phase(input int count, input int idle, input int stall);
    int dz;
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      report_queue.push_back(make_report($urandom_range(0, 9) < 7 ? 0 :
                                         $urandom_range(1, 3)));
    end
    wait_idle();
    dz = $urandom_range(0, 1023);
    set_all(dz, (dz * dz) ^ ($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : 0),
            $urandom_range(0, 1), $urandom_range(0, 127), $urandom_range(0, 65535),
            $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_DEADZONE;
    cfg_wdata = '0;
    mismatch_count = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    shadow_cfg = '0;
    shadow_cfg.pressure_enable = 1'b1;
    pred_primed = 1'b0;
    pred_anchor_x = '0;
    pred_anchor_y = '0;
    pred_smooth_x = '0;
    pred_smooth_y = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed reports under reset settings: ignored, out of proximity, first sample.
    report_queue.push_back(pen_report(8'h40, 16'h0000, 16'h0000, 16'h0000));
    report_queue.push_back(pen_report(8'h4F, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    report_queue.push_back(pen_report(8'hBF, 16'h1234, 16'h5678, 16'h9ABC));
    report_queue.push_back(pen_report(8'h00, 16'h1111, 16'h2222, 16'h3333));
    report_queue.push_back('0);
    report_queue.push_back(in_item_t'({7'd7, 8'h02, 8'h40, {7{8'hFF}}}));
    report_queue.push_back(in_item_t'({7'd9, 8'h55, 8'h02, 8'h41, {6{8'hAA}}}));
    report_queue.push_back(in_item_t'({7'd127, 8'hFF, 8'h02, 8'hFE, {6{8'h55}}}));
    report_queue.push_back(in_item_t'({7'd8, 8'h55, 8'h02, 8'h41, {6{8'h77}}}));
    report_queue.push_back(in_item_t'({7'd64, 8'h03, 8'h04, {7{8'h00}}}));
    wait_idle();

    // Deadband at its largest with smoothing at the cap, tip by threshold.
    set_all(1023, 1046529, 1, 100, 65535, 0, 0);
    report_queue.push_back(pen_report(8'h40, 16'h8000, 16'h8000, 16'hFFFF));
    report_queue.push_back(pen_report(8'h40, 16'h8100, 16'h8000, 16'h0001));
    report_queue.push_back(pen_report(8'h4E, 16'hFFFF, 16'h0000, 16'hFFFE));
    report_queue.push_back(pen_report(8'h41, 16'h0000, 16'hFFFF, 16'h0000));
    wait_idle();

    // Inconsistent squared radius, small deadband, tip disabled.
    set_all(1, 0, 1, 1, 1, 1, 1);
    report_queue.push_back(pen_report(8'h41, 16'h0100, 16'h0100, 16'h0001));
    report_queue.push_back(pen_report(8'h41, 16'h0101, 16'h0100, 16'h0000));
    report_queue.push_back(pen_report(8'h40, 16'h0101, 16'h0101, 16'h0002));
    wait_idle();
    write_reg(REG_DZ_SQUARED, 20'd500);
    write_reg(REG_DEADZONE, 20'd3);
    report_queue.push_back(pen_report(8'h40, 16'h0110, 16'h0100, 16'h0000));
    report_queue.push_back(pen_report(8'h40, 16'h0180, 16'h0100, 16'h0000));

    // Random phases under every idling mix, new settings between them.
    random_phase(350, 0, 0);
    random_phase(350, 58, 0);
    random_phase(350, 0, 58);
    random_phase(350, 24, 24);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
